// ===== hdl/kld_pkg.sv =====
// Package with scanner codes, word table and character classes.
`default_nettype none
package kld_pkg;

	localparam int StateW = 7;
	localparam logic [StateW-1:0] ST_START = 7'd0;
	localparam logic [StateW-1:0] ST_ID    = 7'd1;
	localparam logic [StateW-1:0] ST_NUM   = 7'd2;
	localparam logic [StateW-1:0] ST_COLON = 7'd3;
	localparam logic [StateW-1:0] ST_LT    = 7'd4;
	localparam logic [StateW-1:0] ST_GT    = 7'd5;
	localparam logic [StateW-1:0] ST_PBASE = 7'd6;
	localparam logic [StateW-1:0] ST_PEND  = 7'd69;

	localparam logic [3:0] K_IDCH  = 4'd0;
	localparam logic [3:0] K_NUMCH = 4'd1;
	localparam logic [3:0] K_IDEND = 4'd2;
	localparam logic [3:0] K_NUMEND = 4'd3;
	localparam logic [3:0] K_PUNCT = 4'd4;
	localparam logic [3:0] K_RELOP = 4'd5;
	localparam logic [3:0] K_ADDOP = 4'd6;
	localparam logic [3:0] K_MULOP = 4'd7;
	localparam logic [3:0] K_KEYW  = 4'd8;
	localparam logic [3:0] K_EOF   = 4'd9;
	localparam logic [3:0] K_ERR   = 4'd10;

	localparam int NWords = 15;
	localparam int MaxRes = 11;
	localparam int QueueDepth = 4;

	// One decoded result word.
	typedef struct packed {
		logic [3:0] kind;
		logic [3:0] code;
		logic [7:0] ch;
		logic       last;
	} tok_t;

	// Work handed from the classifier to the emitter.
	typedef struct packed {
		logic [3:0] flush_len;
		logic [3:0] word_idx;
		logic       t1_v;
		tok_t       t1;
		logic       t2_v;
		tok_t       t2;
		logic       t3_v;
		tok_t       t3;
	} job_t;

	function automatic logic [7:0] wchar(input logic [3:0] w, input logic [3:0] i);
		logic [71:0] t;
		case (w)
			4'd0:  t = {"and", 48'd0};
			4'd1:  t = {"or", 56'd0};
			4'd2:  t = {"if", 56'd0};
			4'd3:  t = {"not", 48'd0};
			4'd4:  t = {"end", 48'd0};
			4'd5:  t = {"int", 48'd0};
			4'd6:  t = {"loop", 40'd0};
			4'd7:  t = {"bool", 40'd0};
			4'd8:  t = {"then", 40'd0};
			4'd9:  t = {"else", 40'd0};
			4'd10: t = {"begin", 32'd0};
			4'd11: t = {"while", 32'd0};
			4'd12: t = {"print", 32'd0};
			4'd13: t = {"program", 16'd0};
			4'd14: t = {"procedure"};
			default: t = '0;
		endcase
		wchar = (i < 4'd9) ? t[71 - 8*i -: 8] : 8'd0;
	endfunction

	function automatic logic [3:0] wlen(input logic [3:0] w);
		case (w)
			4'd0, 4'd3, 4'd4, 4'd5: wlen = 4'd3;
			4'd1, 4'd2: wlen = 4'd2;
			4'd6, 4'd7, 4'd8, 4'd9: wlen = 4'd4;
			4'd10, 4'd11, 4'd12: wlen = 4'd5;
			4'd13: wlen = 4'd7;
			4'd14: wlen = 4'd9;
			default: wlen = 4'd0;
		endcase
	endfunction

	function automatic logic [5:0] woff(input logic [3:0] w);
		case (w)
			4'd0: woff = 6'd0;   4'd1: woff = 6'd3;   4'd2: woff = 6'd5;
			4'd3: woff = 6'd7;   4'd4: woff = 6'd10;  4'd5: woff = 6'd13;
			4'd6: woff = 6'd16;  4'd7: woff = 6'd20;  4'd8: woff = 6'd24;
			4'd9: woff = 6'd28;  4'd10: woff = 6'd32; 4'd11: woff = 6'd37;
			4'd12: woff = 6'd42; 4'd13: woff = 6'd47; 4'd14: woff = 6'd54;
			default: woff = 6'd0;
		endcase
	endfunction

	function automatic logic [3:0] wkind(input logic [3:0] w);
		case (w)
			4'd0: wkind = K_MULOP;
			4'd1: wkind = K_ADDOP;
			default: wkind = K_KEYW;
		endcase
	endfunction

	function automatic logic [3:0] wcode(input logic [3:0] w);
		case (w)
			4'd0: wcode = 4'd2;  4'd1: wcode = 4'd2;  4'd2: wcode = 4'd6;
			4'd3: wcode = 4'd12; 4'd4: wcode = 4'd5;  4'd5: wcode = 4'd2;
			4'd6: wcode = 4'd10; 4'd7: wcode = 4'd3;  4'd8: wcode = 4'd7;
			4'd9: wcode = 4'd8;  4'd10: wcode = 4'd4; 4'd11: wcode = 4'd9;
			4'd12: wcode = 4'd11; 4'd13: wcode = 4'd0; 4'd14: wcode = 4'd1;
			default: wcode = 4'd0;
		endcase
	endfunction

	function automatic logic is_letter(input logic [7:0] c);
		is_letter = (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
	endfunction
	function automatic logic is_numeral(input logic [7:0] c);
		is_numeral = c >= "0" && c <= "9";
	endfunction
	function automatic logic is_ws(input logic [7:0] c);
		is_ws = c == " " || (c >= 8'd9 && c <= 8'd13);
	endfunction
	function automatic logic is_id_end(input logic [7:0] c);
		is_id_end = is_ws(c) || c == "$" || c == ";" || c == "," || c == "(" ||
			c == ")" || c == "=" || c == "/" || c == "*" || c == "+" ||
			c == "-" || c == ":" || c == "<" || c == ">";
	endfunction

	function automatic tok_t mk(input logic [3:0] k, input logic [3:0] cd,
			input logic [7:0] ch);
		mk.kind = k;
		mk.code = cd;
		mk.ch = ch;
		mk.last = 1'b0;
	endfunction

endpackage
`default_nettype wire

// ===== hdl/kld_front.sv =====
// Classifier: runs the scan state machine and turns each character into a job.
`default_nettype none
module kld_front import kld_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_ready,
	input  wire logic [7:0] char_code,
	input  wire logic       end_of_input,
	output logic            job_valid,
	input  wire logic       job_ready,
	output job_t            job
);

	logic [StateW-1:0] state_q, st_nx;
	logic halted_q, halt_nx;

	// Prefix decoding of the current state into word and chars held.
	logic [3:0] pw;
	logic [3:0] pn;
	logic [5:0] r;

	always_comb begin
		r = 6'(state_q - ST_PBASE);
		pw = 4'd0;
		pn = 4'd0;
		for (int k = NWords - 1; k >= 0; k--) begin
			if (r >= woff(4'(k)) && r < woff(4'(k)) + 6'(wlen(4'(k)))) begin
				pw = 4'(k);
				pn = 4'(r - woff(4'(k))) + 4'd1;
			end
		end
	end

	// Extension of word w's prefix of n chars by c; returns state or 0.
	function automatic logic [StateW-1:0] extend(input logic [3:0] w,
			input logic [3:0] n, input logic [7:0] c);
		logic hit;
		logic same;
		extend = '0;
		hit = 1'b0;
		for (int k = 0; k < NWords; k++) begin
			same = 1'b1;
			for (int i = 0; i < 8; i++)
				if (4'(i) < n && wchar(4'(k), 4'(i)) != wchar(w, 4'(i)))
					same = 1'b0;
			if (!hit && wlen(4'(k)) > n && same && wchar(4'(k), n) == c) begin
				hit = 1'b1;
				extend = ST_PBASE + 7'(woff(4'(k))) + 7'(n);
			end
		end
	endfunction

	logic [7:0] c;
	job_t j;
	logic err;

	// Start-state scan of one character: emits into the given slot.
	function automatic void start_scan(input logic [7:0] ch,
			output logic v, output tok_t t, output logic [StateW-1:0] ns,
			output logic e);
		logic [StateW-1:0] ex;
		ex = extend(4'd0, 4'd0, ch);
		v = 1'b1;
		t = mk(K_PUNCT, 4'd0, 8'd0);
		ns = ST_START;
		e = 1'b0;
		if (ch == "$") t = mk(K_EOF, 4'd0, 8'd0);
		else if (ch == 8'd0 || is_ws(ch)) v = 1'b0;
		else if (ch == ":") begin v = 1'b0; ns = ST_COLON; end
		else if (ch == "<") begin v = 1'b0; ns = ST_LT; end
		else if (ch == ">") begin v = 1'b0; ns = ST_GT; end
		else if (ch == ";") t = mk(K_PUNCT, 4'd0, 8'd0);
		else if (ch == ",") t = mk(K_PUNCT, 4'd1, 8'd0);
		else if (ch == "(") t = mk(K_PUNCT, 4'd2, 8'd0);
		else if (ch == ")") t = mk(K_PUNCT, 4'd3, 8'd0);
		else if (ch == "=") t = mk(K_RELOP, 4'd0, 8'd0);
		else if (ch == "*") t = mk(K_MULOP, 4'd0, 8'd0);
		else if (ch == "/") t = mk(K_MULOP, 4'd1, 8'd0);
		else if (ch == "+") t = mk(K_ADDOP, 4'd0, 8'd0);
		else if (ch == "-") t = mk(K_ADDOP, 4'd1, 8'd0);
		else if (is_numeral(ch)) begin t = mk(K_NUMCH, 4'd0, ch); ns = ST_NUM; end
		else if (ex != '0) begin v = 1'b0; ns = ex; end
		else if (is_letter(ch)) begin t = mk(K_IDCH, 4'd0, ch); ns = ST_ID; end
		else begin t = mk(K_ERR, 4'd0, 8'd0); e = 1'b1; end
	endfunction

	// Identifier-state scan (used directly and after a flush).
	function automatic void id_scan(input logic [7:0] ch,
			output logic v1, output tok_t t1, output logic v2, output tok_t t2,
			output logic [StateW-1:0] ns, output logic e);
		v2 = 1'b0;
		t2 = mk(K_IDCH, 4'd0, 8'd0);
		v1 = 1'b1;
		e = 1'b0;
		ns = ST_ID;
		if (is_id_end(ch)) begin
			t1 = mk(K_IDEND, 4'd0, 8'd0);
			start_scan(ch, v2, t2, ns, e);
		end else if (is_letter(ch) || is_numeral(ch)) begin
			t1 = mk(K_IDCH, 4'd0, ch);
		end else begin
			t1 = mk(K_ERR, 4'd1, 8'd0);
			e = 1'b1;
			ns = ST_START;
		end
	endfunction

	always_comb begin
		logic [StateW-1:0] ex;
		logic ev, e2;
		c = end_of_input ? "$" : char_code;
		j = '0;
		st_nx = state_q;
		err = 1'b0;
		ex = extend(pw, pn, c);
		ev = 1'b0;
		e2 = 1'b0;
		if (state_q == ST_START || state_q >= ST_PEND) begin
			start_scan(c, j.t1_v, j.t1, st_nx, err);
		end else if (state_q == ST_ID) begin
			id_scan(c, j.t1_v, j.t1, j.t2_v, j.t2, st_nx, err);
		end else if (state_q == ST_NUM) begin
			if (is_letter(c)) begin
				j.t1_v = 1'b1; j.t1 = mk(K_ERR, 4'd2, 8'd0); err = 1'b1;
				st_nx = ST_START;
			end else if (is_numeral(c)) begin
				j.t1_v = 1'b1; j.t1 = mk(K_NUMCH, 4'd0, c);
			end else begin
				j.t1_v = 1'b1; j.t1 = mk(K_NUMEND, 4'd0, 8'd0);
				start_scan(c, j.t2_v, j.t2, st_nx, err);
			end
		end else if (state_q == ST_COLON) begin
			j.t1_v = 1'b1;
			st_nx = ST_START;
			if (c == "=") j.t1 = mk(K_PUNCT, 4'd5, 8'd0);
			else begin
				j.t1 = mk(K_PUNCT, 4'd4, 8'd0);
				start_scan(c, j.t2_v, j.t2, st_nx, err);
			end
		end else if (state_q == ST_LT) begin
			j.t1_v = 1'b1;
			st_nx = ST_START;
			if (c == "=") j.t1 = mk(K_RELOP, 4'd2, 8'd0);
			else if (c == ">") j.t1 = mk(K_RELOP, 4'd3, 8'd0);
			else begin
				j.t1 = mk(K_RELOP, 4'd1, 8'd0);
				start_scan(c, j.t2_v, j.t2, st_nx, err);
			end
		end else if (state_q == ST_GT) begin
			j.t1_v = 1'b1;
			st_nx = ST_START;
			if (c == "=") j.t1 = mk(K_RELOP, 4'd5, 8'd0);
			else begin
				j.t1 = mk(K_RELOP, 4'd4, 8'd0);
				start_scan(c, j.t2_v, j.t2, st_nx, err);
			end
		end else begin
			if (pn == wlen(pw) && !(is_letter(c) || is_numeral(c))) begin
				j.t1_v = 1'b1;
				j.t1 = mk(wkind(pw), wcode(pw), 8'd0);
				start_scan(c, j.t2_v, j.t2, st_nx, err);
			end else if (pn != wlen(pw) && ex != '0) begin
				st_nx = ex;
			end else begin
				// Broken prefix: the held characters go out first.
				j.flush_len = pn;
				j.word_idx = pw;
				id_scan(c, j.t1_v, j.t1, j.t2_v, j.t2, st_nx, err);
				ev = 1'b0;
				e2 = 1'b0;
			end
		end
		if (j.t2_v && j.t2.kind == K_IDEND) begin
			// The third slot is never made valid: t3 takes a copy of t2 with t3_v clear.
			j.t3 = j.t2;
			j.t3_v = 1'b0;
		end
		if (ev || e2) st_nx = ST_START;
		halt_nx = halted_q | err;
	end

	assign in_ready = job_ready || halted_q;
	assign job_valid = in_valid && !halted_q;
	assign job = j;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_START;
			halted_q <= 1'b0;
		end else if (in_valid && in_ready && !halted_q) begin
			state_q <= st_nx;
			halted_q <= halt_nx;
		end
	end

endmodule
`default_nettype wire

// ===== hdl/kld_queue.sv =====
// Short job queue between classifier and emitter.
`default_nettype none
module kld_queue import kld_pkg::*; #(
	parameter int Depth = QueueDepth
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic wr_valid,
	output logic      wr_ready,
	input  wire job_t wr_data,
	output logic      rd_valid,
	input  wire logic rd_ready,
	output job_t      rd_data
);

	localparam int AW = (Depth > 1) ? $clog2(Depth) : 1;

	job_t mem_q [0:Depth-1];
	logic [AW-1:0] wp_q, rp_q;
	logic [AW:0] cnt_q;

	assign wr_ready = cnt_q != (AW+1)'(Depth);
	assign rd_valid = cnt_q != '0;
	assign rd_data = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (wr_valid && wr_ready) mem_q[wp_q] <= wr_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
			cnt_q <= '0;
		end else begin
			if (wr_valid && wr_ready)
				wp_q <= (wp_q == AW'(Depth - 1)) ? '0 : wp_q + 1'b1;
			if (rd_valid && rd_ready)
				rp_q <= (rp_q == AW'(Depth - 1)) ? '0 : rp_q + 1'b1;
			cnt_q <= cnt_q + (AW+1)'(wr_valid && wr_ready)
				- (AW+1)'(rd_valid && rd_ready);
		end
	end

endmodule
`default_nettype wire

// ===== hdl/kld_back.sv =====
// Emitter: sends flushed chars and tokens one word a cycle unless stalled.
`default_nettype none
module kld_back import kld_pkg::*; (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  job_valid,
	output logic       job_ready,
	input  wire job_t  job,
	output logic       out_valid,
	input  wire logic  out_ready,
	output tok_t       out_tok
);

	// Slot list: flush chars (0..flush_len-1), then t1, t2, t3.
	logic [3:0] idx_q;
	logic [3:0] nslots;
	logic [3:0] fl;
	tok_t cur;
	logic cur_v;
	logic is_final;
	logic adv;
	tok_t hold_q;
	logic hold_v_q;

	assign fl = job.flush_len;
	assign nslots = fl + 4'(job.t1_v) + 4'(job.t2_v) + 4'(job.t3_v);

	always_comb begin
		cur_v = 1'b1;
		if (idx_q < fl) cur = mk(K_IDCH, 4'd0, wchar(job.word_idx, idx_q));
		else if (idx_q == fl && job.t1_v) cur = job.t1;
		else if (idx_q == fl + 4'(job.t1_v) && job.t2_v) cur = job.t2;
		else begin
			cur = job.t3;
			cur_v = job.t3_v;
		end
		is_final = (idx_q + 4'd1 >= nslots);
		cur.last = is_final;
	end

	// Output register stage; a new word loads when empty or taken.
	logic load_ok;
	assign load_ok = !hold_v_q || out_ready;
	assign adv = job_valid && load_ok && nslots != '0 && cur_v;
	assign job_ready = job_valid && (nslots == '0 || (adv && is_final));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
			hold_v_q <= 1'b0;
		end else begin
			if (load_ok) hold_v_q <= adv;
			if (job_ready) idx_q <= '0;
			else if (adv) idx_q <= idx_q + 4'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) hold_q <= cur;
	end

	assign out_valid = hold_v_q;
	assign out_tok = hold_q;

endmodule
`default_nettype wire

// ===== hdl/keyword_lexer_dfa_core.sv =====
// Keyword lexer DFA: streaming scanner top level.
// Usage: source characters enter on the s_axis group, one byte per word in
// tdata[7:0], with tlast as the end-of-input flag (acts like '$').
// Result words leave on m_axis: tuser holds token_kind, tdata holds
// token_code[3:0] and lexeme_char[11:4]; tlast marks the final result caused
// by one character.
// The classifier accepts one character per cycle while the queue has room and
// queues a job of up to two tokens and any flushed keyword prefix characters;
// the emitter drains one result word per cycle, while the receiver takes them,
// from a four-entry queue. A job is registered in the queue, then its first
// result in the emitter's output stage. Throughput is one character per cycle
// while each yields at most one result; more results hold up the emitter.
// Reset clears the scan state, the halt flag, the queue and the output stage.
// When the receiver stalls, the output word holds and the queue fills, then
// s_axis_tready falls. After an error result the block drops every further
// character without a result until reset.
`default_nettype none
module keyword_lexer_dfa_core import kld_pkg::*; #(
	parameter int QDepth = QueueDepth
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [7:0]  s_axis_tdata,  // char_code[7:0]
	input  wire logic        s_axis_tlast,
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [15:0]      m_axis_tdata,  // token_code[3:0], lexeme_char[11:4]
	output logic [3:0]       m_axis_tuser,  // token_kind[3:0]
	output logic             m_axis_tlast
);

	logic fq_v, fq_r, qb_v, qb_r;
	job_t fq_d, qb_d;
	tok_t tok;

	kld_front u_front (
		.clk, .arst_n,
		.in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
		.char_code(s_axis_tdata), .end_of_input(s_axis_tlast),
		.job_valid(fq_v), .job_ready(fq_r), .job(fq_d)
	);

	kld_queue #(.Depth(QDepth)) u_queue (
		.clk, .arst_n,
		.wr_valid(fq_v), .wr_ready(fq_r), .wr_data(fq_d),
		.rd_valid(qb_v), .rd_ready(qb_r), .rd_data(qb_d)
	);

	kld_back u_back (
		.clk, .arst_n,
		.job_valid(qb_v), .job_ready(qb_r), .job(qb_d),
		.out_valid(m_axis_tvalid), .out_ready(m_axis_tready), .out_tok(tok)
	);

	assign m_axis_tdata = {4'd0, tok.ch, tok.code};
	assign m_axis_tuser = tok.kind;
	assign m_axis_tlast = tok.last;

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
		&& $stable(m_axis_tuser) && $stable(m_axis_tlast))
		else $error("output word changed while stalled");
	a_kind: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tuser <= K_ERR)
		else $error("token kind out of range");
	a_char: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser != K_IDCH && m_axis_tuser != K_NUMCH
		|-> m_axis_tdata[11:4] == 8'd0)
		else $error("lexeme char set on a non-character token");

endmodule
`default_nettype wire
